// ----- hdl/smae_pkg.sv -----
`default_nettype none

package smae_pkg;

  localparam logic [11:0] TotalCount = 12'd2390;
  localparam int RecipShift = 28;
  localparam logic [16:0] RecipMul = 17'd112316;
  localparam logic [5:0] EndSym = 6'd33;
  localparam int NumLetters = 33;
  localparam int NumCum = 35;
  localparam int NumNoSign = 16;
  localparam int MaxOut = 12;
  localparam int BufIdxW = 4;
  localparam int PendW = 6;

  localparam logic [7:0] CharEnd = 8'h00;
  localparam logic [7:0] CharSoft = 8'hD8;
  localparam logic [7:0] CharHard = 8'hDF;
  localparam logic [7:0] CharYeru = 8'hD9;

  localparam logic [7:0] Letters [NumLetters] = '{
    8'hC1, 8'hC2, 8'hD7, 8'hC7, 8'hC4, 8'hC5, 8'hA3, 8'hD6, 8'hDA, 8'hC9, 8'hCA,
    8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hC6,
    8'hC8, 8'hC3, 8'hDE, 8'hDB, 8'hDD, 8'hDF, 8'hD9, 8'hD8, 8'hDC, 8'hC0, 8'hD1
  };

  localparam logic [11:0] CumTable [NumCum] = '{
    12'd0, 12'd185, 12'd219, 12'd320, 12'd354, 12'd404, 12'd580, 12'd582, 12'd598,
    12'd637, 12'd797, 12'd828, 12'd900, 12'd995, 12'd1068, 12'd1214, 12'd1419,
    12'd1488, 12'd1609, 12'd1724, 12'd1838, 12'd1900, 12'd1907, 12'd1929,
    12'd1939, 12'd1965, 12'd1991, 12'd2005, 12'd2006, 12'd2053, 12'd2089,
    12'd2091, 12'd2114, 12'd2162, 12'd2390
  };

  localparam logic [7:0] NoSignAfter [NumNoSign] = '{
    8'h2B, 8'h2D, 8'h3D, 8'hC1, 8'hC5, 8'hA3, 8'hC9, 8'hCA, 8'hCF, 8'hD5,
    8'hDF, 8'hD9, 8'hD8, 8'hDC, 8'hC0, 8'hD1
  };

  typedef struct packed {
    logic       ok;
    logic [5:0] sym;
  } sym_lookup_t;

  typedef struct packed {
    logic put;
    logic bit_val;
    logic pad;
    logic clr_step;
    logic clr_all;
  } bp_ctrl_t;

  function automatic sym_lookup_t symbol_of(input logic [7:0] c);
    sym_lookup_t r;
    r.ok = 1'b0;
    r.sym = '0;
    if (c == CharEnd) begin
      r.ok = 1'b1;
      r.sym = EndSym;
    end else begin
      for (int i = 0; i < NumLetters; i++) begin
        if (c == Letters[i]) begin
          r.ok = 1'b1;
          r.sym = 6'(i);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [11:0] cum_at(input logic [5:0] k);
    logic [11:0] r;
    r = '0;
    if (k < 6'(NumCum)) begin
      r = CumTable[k];
    end
    return r;
  endfunction

  function automatic logic follows_bad(input logic [7:0] prev);
    logic r;
    r = 1'b0;
    for (int i = 0; i < NumNoSign; i++) begin
      if (prev == NoSignAfter[i]) begin
        r = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/smae_divider.sv -----
`default_nettype none

module smae_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] range_in,
  input  logic [11:0] count_in,
  output logic        done,
  output logic [16:0] quot
);
  import smae_pkg::*;

  typedef enum logic [2:0] {D_IDLE, D_PROD, D_RECIP, D_BACK, D_FIX} div_state_t;

  div_state_t  state_r;
  logic [16:0] range_r;
  logic [11:0] count_r;
  logic [27:0] p_r;
  logic [16:0] q_r;
  logic [12:0] rem_r;
  logic [27:0] mul_a;
  logic [16:0] mul_b;
  logic [44:0] mul_p;
  logic [27:0] back_diff;

  // One multiplier serves the product, the reciprocal step and the back-multiply.
  always_comb begin
    mul_a = 28'(range_r);
    mul_b = 17'(count_r);
    unique case (state_r)
      D_RECIP: begin
        mul_a = p_r;
        mul_b = RecipMul;
      end
      D_BACK: begin
        mul_a = 28'(q_r);
        mul_b = 17'(TotalCount);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = 45'(mul_a) * 45'(mul_b);
  assign back_diff = p_r - mul_p[27:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      unique case (state_r)
        D_IDLE, D_FIX: state_r <= start ? D_PROD : D_IDLE;
        D_PROD:        state_r <= D_RECIP;
        D_RECIP:       state_r <= D_BACK;
        D_BACK:        state_r <= D_FIX;
        default:       state_r <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == D_IDLE || state_r == D_FIX) && start) begin
      range_r <= range_in;
      count_r <= count_in;
    end
    if (state_r == D_PROD) begin
      p_r <= mul_p[27:0];
    end
    if (state_r == D_RECIP) begin
      q_r <= mul_p[RecipShift+16:RecipShift];
    end
    if (state_r == D_BACK) begin
      rem_r <= back_diff[12:0];
    end
  end

  // The reciprocal estimate is low by at most one.
  assign done = (state_r == D_FIX);
  assign quot = q_r + 17'(rem_r >= 13'(TotalCount));

endmodule

`default_nettype wire

// ----- hdl/smae_bitpack.sv -----
`default_nettype none

module smae_bitpack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smae_pkg::bp_ctrl_t            ctrl,
  input  logic [smae_pkg::BufIdxW-1:0]  rd_idx,
  output logic [7:0]                    rd_data,
  output logic [smae_pkg::BufIdxW-1:0]  count,
  output logic [7:0]                    total
);
  import smae_pkg::*;

  logic [7:0]         acc_r, acc_nxt;
  logic [2:0]         pos_r, pos_nxt;
  logic [7:0]         total_r, total_nxt;
  logic [BufIdxW-1:0] count_r, count_nxt;
  logic               push;
  logic [7:0]         push_data;
  logic [7:0]         byte_mem_r [MaxOut];

  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    total_nxt = total_r;
    count_nxt = count_r;
    push = 1'b0;
    push_data = acc_r;
    if (ctrl.put) begin
      push_data = acc_r | ({ctrl.bit_val, 7'b0} >> pos_r);
      acc_nxt = push_data;
      pos_nxt = pos_r + 3'd1;
      if (pos_r == 3'd7) begin
        push = 1'b1;
        acc_nxt = '0;
      end
    end else if (ctrl.pad) begin
      push = (pos_r != 3'd0);
    end
    if (push) begin
      if (total_r != 8'hFF) begin
        total_nxt = total_r + 8'd1;
      end
      if (count_r < BufIdxW'(MaxOut)) begin
        count_nxt = count_r + BufIdxW'(1);
      end
    end
    if (ctrl.clr_step) begin
      count_nxt = '0;
    end
    if (ctrl.clr_all) begin
      acc_nxt = '0;
      pos_nxt = '0;
      total_nxt = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
      total_r <= '0;
      count_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
      total_r <= total_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && count_r < BufIdxW'(MaxOut)) begin
      byte_mem_r[count_r] <= push_data;
    end
  end

  assign rd_data = byte_mem_r[rd_idx];
  assign count = count_r;
  assign total = total_r;

endmodule

`default_nettype wire

// ----- hdl/static_model_arith_encoder_core.sv -----
// Static-model arithmetic encoder for one word of 8-bit Cyrillic text.
// Input channel: one character per request on in_char_code; code 0 ends the
// word. Output channel: the packed key bytes, MSB first. The last byte of a
// word carries out_is_last and the byte count in out_key_length. A bad
// character, a bad letter pair or too many pending underflow bits yields a
// single request with out_is_error and out_is_last set, and the encoder
// returns to the start of a word.
// The block handles one character at a time and is not ready meanwhile.
// Per character: it accepts the character, checks it, scales the bounds twice
// through the shared multiply-by-reciprocal divider, takes a renormalization
// step per shift and emits each pending bit in turn, settles, and then offers
// its output bytes in order, or goes back to idle when there are none. An end
// of word flushes two bits plus the pending bits, then pads a partial last
// byte. All bytes of one character are collected first and only then offered,
// so an error clears them. When the receiver stalls, the current request
// holds and the block stays busy. After reset the bounds are full range and
// the next character starts a new word.
`default_nettype none

module static_model_arith_encoder_core #(
  parameter int MAX_PENDING = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_packed_byte,
  output logic       out_is_last,
  output logic       out_is_error,
  output logic [7:0] out_key_length
);
  import smae_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV_HI, S_DIV_LO, S_RENORM, S_PEND,
    S_FLUSH, S_FTAIL, S_PAD, S_OUT, S_ERR
  } enc_state_t;

  localparam logic [PendW-1:0] PendLimit = PendW'(MAX_PENDING);

  enc_state_t         state_r, state_nxt;
  logic [7:0]         char_r, char_nxt;
  logic [5:0]         sym_r, sym_nxt;
  logic               end_r, end_nxt;
  logic [15:0]        low_r, low_nxt;
  logic [15:0]        high_r, high_nxt;
  logic [15:0]        lo_w_r, lo_w_nxt;
  logic [15:0]        hi_w_r, hi_w_nxt;
  logic [PendW-1:0]   pend_r, pend_nxt;
  logic               obit_r, obit_nxt;
  logic [PendW:0]     fcnt_r, fcnt_nxt;
  logic [7:0]         prev_r, prev_nxt;
  logic               first_r, first_nxt;
  logic [BufIdxW-1:0] rd_idx_r, rd_idx_nxt;

  sym_lookup_t        lookup;
  logic               bad_pair;
  logic               clear_word;
  bp_ctrl_t           bp;
  logic [7:0]         bp_rd;
  logic [BufIdxW-1:0] bp_count;
  logic [7:0]         bp_total;
  logic               div_start;
  logic [11:0]        div_count;
  logic [16:0]        div_range;
  logic               div_done;
  logic [16:0]        div_quot;
  logic               last_hit;

  assign lookup = symbol_of(char_r);
  assign bad_pair = first_r
    ? (char_r == CharEnd || char_r == CharSoft || char_r == CharYeru || char_r == CharHard)
    : ((char_r == CharSoft || char_r == CharHard) && follows_bad(prev_r));
  assign div_range = {1'b0, high_r} - {1'b0, low_r} + 17'd1;
  assign last_hit = (rd_idx_r == bp_count - BufIdxW'(1));

  always_comb begin
    state_nxt = state_r;
    char_nxt = char_r;
    sym_nxt = sym_r;
    end_nxt = end_r;
    low_nxt = low_r;
    high_nxt = high_r;
    lo_w_nxt = lo_w_r;
    hi_w_nxt = hi_w_r;
    pend_nxt = pend_r;
    obit_nxt = obit_r;
    fcnt_nxt = fcnt_r;
    prev_nxt = prev_r;
    first_nxt = first_r;
    rd_idx_nxt = rd_idx_r;
    bp = '0;
    div_start = 1'b0;
    div_count = cum_at(sym_r);
    clear_word = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          char_nxt = in_char_code;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (lookup.ok && !bad_pair) begin
          sym_nxt = lookup.sym;
          end_nxt = (lookup.sym == EndSym);
          div_start = 1'b1;
          div_count = cum_at(lookup.sym + 6'd1);
          state_nxt = S_DIV_HI;
        end else begin
          clear_word = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_DIV_HI: begin
        if (div_done) begin
          hi_w_nxt = low_r + div_quot[15:0] - 16'd1;
          div_start = 1'b1;
          state_nxt = S_DIV_LO;
        end
      end
      S_DIV_LO: begin
        if (div_done) begin
          lo_w_nxt = low_r + div_quot[15:0];
          state_nxt = S_RENORM;
        end
      end
      S_RENORM: begin
        if (hi_w_r[15] == lo_w_r[15]) begin
          bp.put = 1'b1;
          bp.bit_val = hi_w_r[15];
          obit_nxt = hi_w_r[15];
          if (pend_r == '0) begin
            lo_w_nxt = {lo_w_r[14:0], 1'b0};
            hi_w_nxt = {hi_w_r[14:0], 1'b1};
          end else begin
            state_nxt = S_PEND;
          end
        end else if (lo_w_r[14] && !hi_w_r[14]) begin
          if (pend_r >= PendLimit) begin
            clear_word = 1'b1;
            state_nxt = S_ERR;
          end else begin
            pend_nxt = pend_r + PendW'(1);
            lo_w_nxt = {1'b0, lo_w_r[13:0], 1'b0};
            hi_w_nxt = {1'b1, hi_w_r[13:0], 1'b1};
          end
        end else begin
          low_nxt = lo_w_r;
          high_nxt = hi_w_r;
          if (end_r) begin
            state_nxt = S_FLUSH;
          end else begin
            prev_nxt = char_r;
            first_nxt = 1'b0;
            state_nxt = S_OUT;
          end
        end
      end
      S_PEND: begin
        bp.put = 1'b1;
        bp.bit_val = ~obit_r;
        pend_nxt = pend_r - PendW'(1);
        if (pend_r == PendW'(1)) begin
          lo_w_nxt = {lo_w_r[14:0], 1'b0};
          hi_w_nxt = {hi_w_r[14:0], 1'b1};
          state_nxt = S_RENORM;
        end
      end
      S_FLUSH: begin
        bp.put = 1'b1;
        bp.bit_val = lo_w_r[14];
        obit_nxt = lo_w_r[14];
        fcnt_nxt = {1'b0, pend_r} + (PendW+1)'(1);
        state_nxt = S_FTAIL;
      end
      S_FTAIL: begin
        bp.put = 1'b1;
        bp.bit_val = ~obit_r;
        fcnt_nxt = fcnt_r - (PendW+1)'(1);
        if (fcnt_r == (PendW+1)'(1)) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        bp.pad = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (bp_count == '0) begin
          clear_word = end_r;
          state_nxt = S_IDLE;
        end else if (out_ready) begin
          if (last_hit) begin
            bp.clr_step = 1'b1;
            rd_idx_nxt = '0;
            clear_word = end_r;
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + BufIdxW'(1);
          end
        end
      end
      S_ERR: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (clear_word) begin
      low_nxt = '0;
      high_nxt = 16'hFFFF;
      pend_nxt = '0;
      prev_nxt = '0;
      first_nxt = 1'b1;
      bp.clr_all = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      end_r <= 1'b0;
      low_r <= '0;
      high_r <= 16'hFFFF;
      pend_r <= '0;
      prev_r <= '0;
      first_r <= 1'b1;
      rd_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      end_r <= end_nxt;
      low_r <= low_nxt;
      high_r <= high_nxt;
      pend_r <= pend_nxt;
      prev_r <= prev_nxt;
      first_r <= first_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
    char_r <= char_nxt;
    sym_r <= sym_nxt;
    lo_w_r <= lo_w_nxt;
    hi_w_r <= hi_w_nxt;
    obit_r <= obit_nxt;
    fcnt_r <= fcnt_nxt;
  end

  smae_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .range_in (div_range),
    .count_in (div_count),
    .done     (div_done),
    .quot     (div_quot)
  );

  smae_bitpack u_bitpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (bp),
    .rd_idx  (rd_idx_r),
    .rd_data (bp_rd),
    .count   (bp_count),
    .total   (bp_total)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_ERR) || (state_r == S_OUT && bp_count != '0);
  assign out_is_error = (state_r == S_ERR);
  assign out_is_last = (state_r == S_ERR) || (state_r == S_OUT && end_r && last_hit);
  assign out_packed_byte = (state_r == S_ERR) ? 8'h00 : bp_rd;
  assign out_key_length = (state_r == S_OUT && end_r && last_hit) ? bp_total : 8'h00;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_error) |-> (out_is_last && out_packed_byte == 8'h00))
    else $error("malformed error result");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PendLimit)
    else $error("pending bit count beyond its bound");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_HI || state_r == S_DIV_LO))
    else $error("divider finished outside a scaling step");

endmodule

`default_nettype wire

// ----- sim/arith_key_checker.sv -----
`timescale 1ns / 1ps

module arith_key_checker #(
  parameter int MAX_PENDING = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_packed_byte,
  input  logic       out_is_last,
  input  logic       out_is_error,
  input  logic [7:0] out_key_length,
  output int         fail_count,
  output int         n_waiting
);
  import smae_pkg::*;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       last;
    logic       err;
    logic [7:0] klen;
  } key_item_t;

  localparam logic [0:32][7:0] Alphabet = {
    8'hC1, 8'hC2, 8'hD7, 8'hC7, 8'hC4, 8'hC5, 8'hA3, 8'hD6, 8'hDA, 8'hC9, 8'hCA,
    8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hC6,
    8'hC8, 8'hC3, 8'hDE, 8'hDB, 8'hDD, 8'hDF, 8'hD9, 8'hD8, 8'hDC, 8'hC0, 8'hD1
  };

  localparam logic [0:34][11:0] CumAt = {
    12'd0, 12'd185, 12'd219, 12'd320, 12'd354, 12'd404, 12'd580, 12'd582, 12'd598,
    12'd637, 12'd797, 12'd828, 12'd900, 12'd995, 12'd1068, 12'd1214, 12'd1419,
    12'd1488, 12'd1609, 12'd1724, 12'd1838, 12'd1900, 12'd1907, 12'd1929,
    12'd1939, 12'd1965, 12'd1991, 12'd2005, 12'd2006, 12'd2053, 12'd2089,
    12'd2091, 12'd2114, 12'd2162, 12'd2390
  };

  // Vowels, signs and the three punctuation marks; no sign may follow them.
  localparam logic [0:15][7:0] SignBlockers = {
    8'h2B, 8'h2D, 8'h3D, 8'hC1, 8'hC5, 8'hA3, 8'hC9, 8'hCA, 8'hCF, 8'hD5,
    8'hDF, 8'hD9, 8'hD8, 8'hDC, 8'hC0, 8'hD1
  };

  logic [15:0] lo_b, hi_b;
  logic [5:0]  pend_cnt;
  logic [7:0]  acc_byte, byte_cnt, prev_ch;
  logic [2:0]  bit_pos;
  logic        word_start;
  logic [7:0]  step_bytes[$];
  key_item_t   key_due[$];

  function automatic int alphabet_index(input logic [7:0] c);
    int idx;
    idx = -1;
    if (c == CharEnd) begin
      idx = int'(EndSym);
    end else begin
      for (int i = 0; i < 33; i++) begin
        if (Alphabet[i] == c) begin
          idx = i;
        end
      end
    end
    return idx;
  endfunction

  function automatic logic blocks_sign(input logic [7:0] prev);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (SignBlockers[i] == prev) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic clear_coder();
    lo_b = 16'h0000;
    hi_b = 16'hFFFF;
    pend_cnt = '0;
    acc_byte = '0;
    bit_pos = '0;
    byte_cnt = '0;
    prev_ch = CharEnd;
    word_start = 1'b1;
  endtask

  task automatic note_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string label, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s is %0h, expected %0h", label, got, want));
    end
  endtask

  task automatic put_bit(input logic b);
    if (b) begin
      acc_byte[3'd7 - bit_pos] = 1'b1;
    end
    bit_pos = bit_pos + 3'd1;
    if (bit_pos == 3'd0) begin
      if (step_bytes.size() < MaxOut) begin
        step_bytes.push_back(acc_byte);
      end
      if (byte_cnt != 8'hFF) begin
        byte_cnt = byte_cnt + 8'd1;
      end
      acc_byte = '0;
    end
  endtask

  task automatic encode_char(input logic [7:0] c);
    int sym;
    int flush_n;
    logic [31:0] rng, lo, hi;
    logic b;
    logic bad, settled;
    key_item_t item;
    step_bytes.delete();
    sym = alphabet_index(c);
    if (word_start) begin
      bad = (c == CharEnd || c == CharSoft || c == CharYeru || c == CharHard);
    end else begin
      bad = (c == CharSoft || c == CharHard) && blocks_sign(prev_ch);
    end
    bad = bad || (sym < 0);
    if (!bad) begin
      lo = {16'h0000, lo_b};
      hi = {16'h0000, hi_b};
      rng = hi - lo + 32'd1;
      hi = (lo + rng * CumAt[sym + 1] / TotalCount - 32'd1) & 32'hFFFF;
      lo = (lo + rng * CumAt[sym] / TotalCount) & 32'hFFFF;
      settled = 1'b0;
      while (!settled && !bad) begin
        if (hi[15] == lo[15]) begin
          b = hi[15];
          put_bit(b);
          while (pend_cnt != 0) begin
            put_bit(!b);
            pend_cnt = pend_cnt - 6'd1;
          end
        end else if (lo[14] && !hi[14]) begin
          if (pend_cnt >= MAX_PENDING) begin
            bad = 1'b1;
          end else begin
            pend_cnt = pend_cnt + 6'd1;
            lo[14] = 1'b0;
            hi[14] = 1'b1;
          end
        end else begin
          settled = 1'b1;
        end
        if (!settled && !bad) begin
          lo = {lo[30:0], 1'b0} & 32'hFFFF;
          hi = {hi[30:0], 1'b1} & 32'hFFFF;
        end
      end
    end
    if (bad) begin
      item.pbyte = '0;
      item.last = 1'b1;
      item.err = 1'b1;
      item.klen = '0;
      key_due.push_back(item);
      clear_coder();
    end else begin
      lo_b = lo[15:0];
      hi_b = hi[15:0];
      if (sym == int'(EndSym)) begin
        b = lo[14];
        flush_n = int'(pend_cnt) + 1;
        put_bit(b);
        repeat (flush_n) put_bit(!b);
        if (bit_pos != 3'd0) begin
          if (step_bytes.size() < MaxOut) begin
            step_bytes.push_back(acc_byte);
          end
          if (byte_cnt != 8'hFF) begin
            byte_cnt = byte_cnt + 8'd1;
          end
        end
      end
      foreach (step_bytes[i]) begin
        item.pbyte = step_bytes[i];
        item.last = 1'b0;
        item.err = 1'b0;
        item.klen = '0;
        if (sym == int'(EndSym) && i == step_bytes.size() - 1) begin
          item.last = 1'b1;
          item.klen = byte_cnt;
        end
        key_due.push_back(item);
      end
      if (sym == int'(EndSym)) begin
        clear_coder();
      end else begin
        prev_ch = c;
        word_start = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    key_item_t want;
    if (!rst_n) begin
      clear_coder();
      key_due.delete();
      fail_count = 0;
    end else begin
      if ($isunknown({in_ready, out_valid})) begin
        note_mismatch("handshake output is unknown");
      end
      if (in_valid && in_ready) begin
        encode_char(in_char_code);
      end
      if (out_valid && out_ready) begin
        if (key_due.size() == 0) begin
          note_mismatch($sformatf("unexpected key byte %0h", out_packed_byte));
        end else begin
          want = key_due.pop_front();
          check_field("packed_byte", out_packed_byte, want.pbyte);
          check_field("is_last", {7'd0, out_is_last}, {7'd0, want.last});
          check_field("is_error", {7'd0, out_is_error}, {7'd0, want.err});
          check_field("key_length", out_key_length, want.klen);
        end
      end
    end
    n_waiting <= key_due.size();
  end

endmodule

// ----- sim/static_model_arith_encoder_core_tb.sv -----
`timescale 1ns / 1ps

module static_model_arith_encoder_core_tb;
  import smae_pkg::*;

  localparam int MaxPend = 32;

  localparam logic [0:23][7:0] DirectedCodes = {
    CharEnd, CharSoft, CharYeru, CharHard, 8'h01, 8'hFF,
    8'hC2, CharSoft, CharYeru, CharHard, CharEnd,
    8'hC1, CharSoft, 8'hC5, CharHard, 8'hC1, CharEnd,
    8'hD1, 8'hC0, 8'hA3, CharEnd, 8'h2B, 8'h7F, 8'h80
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_packed_byte;
  logic       out_is_last;
  logic       out_is_error;
  logic [7:0] out_key_length;

  int fail_count;
  int n_waiting;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  logic [31:0] trk_lo, trk_hi;
  int          trk_pend;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  static_model_arith_encoder_core #(
    .MAX_PENDING(MaxPend)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_packed_byte(out_packed_byte),
    .out_is_last(out_is_last),
    .out_is_error(out_is_error),
    .out_key_length(out_key_length)
  );

  arith_key_checker #(
    .MAX_PENDING(MaxPend)
  ) u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_packed_byte(out_packed_byte),
    .out_is_last(out_is_last),
    .out_is_error(out_is_error),
    .out_key_length(out_key_length),
    .fail_count(fail_count),
    .n_waiting(n_waiting)
  );

  task automatic send_char(input logic [7:0] c);
    in_valid <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    sent++;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic int plain_index();
    int k;
    do begin
      k = $urandom_range(0, NumLetters - 1);
    end while (Letters[k] == CharSoft || Letters[k] == CharHard || Letters[k] == CharYeru);
    return k;
  endfunction

  task automatic send_plain_word(input bit mutate);
    int len;
    int bad_at;
    logic [7:0] c;
    logic [7:0] prev;
    len = $urandom_range(1, 8);
    bad_at = mutate ? $urandom_range(0, len - 1) : -1;
    prev = CharEnd;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        c = Letters[plain_index()];
      end else begin
        c = Letters[$urandom_range(0, NumLetters - 1)];
        if ((c == CharSoft || c == CharHard) && follows_bad(prev)) begin
          c = Letters[plain_index()];
        end
      end
      if (i == bad_at) begin
        c = 8'($urandom_range(0, 255));
      end
      send_char(c);
      prev = c;
    end
    send_char(CharEnd);
  endtask

  task automatic send_noise_word();
    repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
    send_char(CharEnd);
  endtask

  // Rare letters only, long enough for the key length to saturate.
  task automatic send_long_word();
    repeat (230) send_char($urandom_range(0, 1) ? 8'hA3 : 8'hDC);
    send_char(CharEnd);
  endtask

  // Follows the coder bounds so that the next letter can be chosen to keep
  // the interval across the midpoint and pile up underflow bits.
  task automatic track_symbol(input int k, output bit ovf);
    logic [31:0] rng;
    bit busy;
    ovf = 1'b0;
    busy = 1'b1;
    rng = trk_hi - trk_lo + 32'd1;
    trk_hi = (trk_lo + rng * CumTable[k + 1] / TotalCount - 32'd1) & 32'hFFFF;
    trk_lo = (trk_lo + rng * CumTable[k] / TotalCount) & 32'hFFFF;
    while (busy) begin
      if (trk_hi[15] == trk_lo[15]) begin
        trk_pend = 0;
      end else if (trk_lo[14] && !trk_hi[14]) begin
        if (trk_pend >= MaxPend) begin
          ovf = 1'b1;
          busy = 1'b0;
        end else begin
          trk_pend++;
          trk_lo[14] = 1'b0;
          trk_hi[14] = 1'b1;
        end
      end else begin
        busy = 1'b0;
      end
      if (busy) begin
        trk_lo = {trk_lo[30:0], 1'b0} & 32'hFFFF;
        trk_hi = {trk_hi[30:0], 1'b1} & 32'hFFFF;
      end
    end
  endtask

  function automatic int mid_symbol();
    logic [31:0] rng, lo_n, hi_n;
    int pick;
    pick = int'(EndSym);
    rng = trk_hi - trk_lo + 32'd1;
    for (int k = 0; k <= int'(EndSym); k++) begin
      lo_n = trk_lo + rng * CumTable[k] / TotalCount;
      hi_n = trk_lo + rng * CumTable[k + 1] / TotalCount - 32'd1;
      if (lo_n <= 32'h8000 && hi_n >= 32'h8000) begin
        pick = k;
      end
    end
    return pick;
  endfunction

  task automatic send_steered_word();
    int k;
    int steps;
    bit ovf;
    bit stop;
    logic [7:0] c;
    trk_lo = 32'h0000;
    trk_hi = 32'hFFFF;
    trk_pend = 0;
    ovf = 1'b0;
    stop = 1'b0;
    steps = 0;
    repeat ($urandom_range(1, 4)) begin
      if (!ovf) begin
        k = plain_index();
        send_char(Letters[k]);
        track_symbol(k, ovf);
      end
    end
    while (!ovf && !stop) begin
      k = mid_symbol();
      if (k == int'(EndSym) || steps == 60) begin
        stop = 1'b1;
      end else begin
        c = Letters[k];
        if (c == CharSoft || c == CharHard || c == CharYeru) begin
          stop = 1'b1;
        end else begin
          send_char(c);
          track_symbol(k, ovf);
          steps++;
        end
      end
    end
    if (!ovf) begin
      send_char(CharEnd);
    end
  endtask

  initial begin : stimulus
    int start;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 24; i++) begin
      send_char(DirectedCodes[i]);
    end
    send_steered_word();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct = 10;
          stall_pct = 10;
        end
      endcase
      if (p == 1) begin
        send_long_word();
      end
      start = sent;
      while (sent - start < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_plain_word(1'b0);
        end else if (pick < 75) begin
          send_steered_word();
        end else if (pick < 90) begin
          send_plain_word(1'b1);
        end else begin
          send_noise_word();
        end
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
